### hw/rtl/ghb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghb_pkg
// shared types and constants of the grid heat map binning core
// ----------------------------------------------------------------------------
package ghb_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int STORE_DEPTH   = 65536;
    localparam int ADDR_W        = 16;
    localparam int CNT_W         = 16;
    localparam int POS_W         = 18;
    localparam int CPS_W         = 9;
    localparam int Q_W           = 11;

    // one cell is 160 lsb: shift by 5, then divide by 5 through a reciprocal
    localparam int RECIP_FIVE    = 6554;
    localparam int PROD_W        = 26;

    localparam logic signed [POS_W-1:0] TOP_EDGE_RST = 18'sd28000;
    localparam logic [CPS_W-1:0]        CPS_RST      = 9'd225;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        REG_TOP_EDGE_X   = 2'd0,
        REG_TOP_EDGE_Y   = 2'd1,
        REG_CELLS_PER_SIDE = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHK,
        ST_RD,
        ST_MOD
    } t_state;

endpackage

### hw/rtl/grid_heatmap_binning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_heatmap_binning_core
// two-dimensional histogram of points on a square grid with a counter memory
//
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+-----------------
// command  | i_opcode i_x_pos i_y_pos i_cell_index          | i_start, o_busy
// result   | o_counted o_hit_cell o_cell_count o_max_count  | o_strobe
// config   | i_cfg_index i_cfg_data                         | i_cfg_valid/ready
//
// an add or read passes through the divide, check, memory read and write-back
// steps before the next command can be accepted; a skipped add returns to idle
// after the check. the result strobe is high for one cycle as busy falls.
// after reset a clearing pass zeroes the counter memory,
// busy stays high meanwhile; config writes are always taken.
// ----------------------------------------------------------------------------
module grid_heatmap_binning_core #(
    parameter int GRID_SIDE = ghb_pkg::GRID_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_opcode,
    input  logic signed [ghb_pkg::POS_W-1:0]   i_x_pos,
    input  logic signed [ghb_pkg::POS_W-1:0]   i_y_pos,
    input  logic        [ghb_pkg::ADDR_W-1:0]  i_cell_index,
    output logic                               o_strobe,
    output logic                               o_counted,
    output logic        [ghb_pkg::ADDR_W-1:0]  o_hit_cell,
    output logic        [ghb_pkg::CNT_W-1:0]   o_cell_count,
    output logic        [ghb_pkg::CNT_W-1:0]   o_max_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic        [1:0]                  i_cfg_index,
    input  logic        [ghb_pkg::POS_W-1:0]   i_cfg_data
);

    localparam int POS_W  = ghb_pkg::POS_W;
    localparam int Q_W    = ghb_pkg::Q_W;
    localparam int CNT_W  = ghb_pkg::CNT_W;
    localparam int ADDR_W = ghb_pkg::ADDR_W;
    localparam int PROD_W = ghb_pkg::PROD_W;
    localparam int IDX_RAW_W = Q_W + $clog2(GRID_SIDE) + 1;
    localparam int IDX_W  = (IDX_RAW_W > ADDR_W + 1) ? IDX_RAW_W : ADDR_W + 1;

    ghb_pkg::t_state r_state, n_state;

    logic signed [POS_W-1:0] r_top_x, r_top_y;
    logic [ghb_pkg::CPS_W-1:0] r_cps;

    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]  r_max, n_max;
    logic              r_strobe, n_strobe;

    logic                    r_op, n_op;
    logic signed [POS_W-1:0] r_x, n_x, r_y, n_y;
    logic [ADDR_W-1:0]       r_cidx, n_cidx;
    logic signed [POS_W:0]   r_dx, n_dx, r_dy, n_dy;
    logic [PROD_W-1:0]       r_prod_x, n_prod_x, r_prod_y, n_prod_y;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic                    r_counted, n_counted;
    logic [ADDR_W-1:0]       r_hit, n_hit;
    logic [CNT_W-1:0]        r_cnt, n_cnt, r_max_out, n_max_out;

    logic [CNT_W-1:0] r_mem [0:ghb_pkg::STORE_DEPTH-1];
    logic [CNT_W-1:0] r_rdata;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CNT_W-1:0]  w_wdata;

    logic [Q_W-1:0]   w_qx, w_qy, w_side;
    logic             w_inx, w_iny, w_land;
    logic [IDX_W-1:0] w_idx;
    logic [CNT_W-1:0] w_inc;

    function automatic logic [POS_W-1:0] times_cell(input logic [Q_W-1:0] q);
        return {q, 7'b0} + {2'b0, q, 5'b0};
    endfunction

    assign o_busy       = (r_state != ghb_pkg::ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_counted    = r_counted;
    assign o_hit_cell   = r_hit;
    assign o_cell_count = r_cnt;
    assign o_max_count  = r_max_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_x <= ghb_pkg::TOP_EDGE_RST;
            r_top_y <= ghb_pkg::TOP_EDGE_RST;
            r_cps   <= ghb_pkg::CPS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ghb_pkg::REG_TOP_EDGE_X:     r_top_x <= i_cfg_data;
                ghb_pkg::REG_TOP_EDGE_Y:     r_top_y <= i_cfg_data;
                ghb_pkg::REG_CELLS_PER_SIDE: r_cps   <= i_cfg_data[ghb_pkg::CPS_W-1:0];
                default: ;
            endcase
        end
    end

    // counter memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // axis checks
    always_comb begin
        w_side = ({2'b0, r_cps} > Q_W'(GRID_SIDE)) ? Q_W'(GRID_SIDE) : Q_W'(r_cps);
        w_qx   = r_prod_x[PROD_W-1:15];
        w_qy   = r_prod_y[PROD_W-1:15];
        w_inx  = !r_dx[POS_W] && (r_dx != '0) && (r_dx[POS_W-1:0] != times_cell(w_qx))
                 && (w_qx < w_side);
        w_iny  = !r_dy[POS_W] && (r_dy != '0) && (r_dy[POS_W-1:0] != times_cell(w_qy))
                 && (w_qy < w_side);
        w_idx  = IDX_W'(w_qx) * IDX_W'(GRID_SIDE) + IDX_W'(w_qy);
        w_land = (r_x != '0) && (r_y != '0) && w_inx && w_iny
                 && (w_idx[IDX_W-1:ADDR_W] == '0);
        w_inc  = (r_rdata == '1) ? r_rdata : r_rdata + CNT_W'(1);
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_max      = r_max;
        n_strobe   = 1'b0;
        n_op       = r_op;
        n_x        = r_x;
        n_y        = r_y;
        n_cidx     = r_cidx;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_prod_x   = r_prod_x;
        n_prod_y   = r_prod_y;
        n_addr     = r_addr;
        n_counted  = r_counted;
        n_hit      = r_hit;
        n_cnt      = r_cnt;
        n_max_out  = r_max_out;
        w_we       = 1'b0;
        w_waddr    = r_addr;
        w_wdata    = w_inc;
        case (r_state)
            ghb_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = ghb_pkg::ST_IDLE;
                end
            end
            ghb_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_x     = i_x_pos;
                    n_y     = i_y_pos;
                    n_cidx  = i_cell_index;
                    n_state = ghb_pkg::ST_DIV;
                end
            end
            ghb_pkg::ST_DIV: begin
                n_dx     = {r_top_x[POS_W-1], r_top_x} - {r_x[POS_W-1], r_x};
                n_dy     = {r_top_y[POS_W-1], r_top_y} - {r_y[POS_W-1], r_y};
                n_prod_x = PROD_W'(n_dx[POS_W-1:5]) * PROD_W'(ghb_pkg::RECIP_FIVE);
                n_prod_y = PROD_W'(n_dy[POS_W-1:5]) * PROD_W'(ghb_pkg::RECIP_FIVE);
                n_state  = ghb_pkg::ST_CHK;
            end
            ghb_pkg::ST_CHK: begin
                if (r_op == ghb_pkg::OP_READ) begin
                    n_addr  = r_cidx;
                    n_state = ghb_pkg::ST_RD;
                end else if (w_land) begin
                    n_addr  = w_idx[ADDR_W-1:0];
                    n_state = ghb_pkg::ST_RD;
                end else begin
                    n_strobe  = 1'b1;
                    n_counted = 1'b0;
                    n_hit     = '0;
                    n_cnt     = '0;
                    n_max_out = r_max;
                    n_state   = ghb_pkg::ST_IDLE;
                end
            end
            ghb_pkg::ST_RD: begin
                n_state = ghb_pkg::ST_MOD;
            end
            ghb_pkg::ST_MOD: begin
                n_strobe = 1'b1;
                n_hit    = r_addr;
                if (r_op == ghb_pkg::OP_READ) begin
                    n_counted = 1'b0;
                    n_cnt     = r_rdata;
                    n_max_out = r_max;
                end else begin
                    w_we      = 1'b1;
                    n_counted = 1'b1;
                    n_cnt     = w_inc;
                    n_max     = (w_inc > r_max) ? w_inc : r_max;
                    n_max_out = n_max;
                end
                n_state = ghb_pkg::ST_IDLE;
            end
            default: begin
                n_state = ghb_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ghb_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_max      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_max      <= n_max;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_x       <= n_x;
        r_y       <= n_y;
        r_cidx    <= n_cidx;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_prod_x  <= n_prod_x;
        r_prod_y  <= n_prod_y;
        r_addr    <= n_addr;
        r_counted <= n_counted;
        r_hit     <= n_hit;
        r_cnt     <= n_cnt;
        r_max_out <= n_max_out;
    end

endmodule
